// File: sv/random_free_cell_picker_unit_assert.svh
// assertion macros used by the checker file
`ifndef RANDOM_FREE_CELL_PICKER_UNIT_ASSERT_SVH
`define RANDOM_FREE_CELL_PICKER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RFCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RFCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rfcp_pkg.sv
// shared widths and codes of the free cell picker
package rfcp_pkg;

  localparam int CFG_W   = 13;  // column_count / row_count width
  localparam int RAND_W  = 31;  // random_word width
  localparam int OUT_W   = 12;  // row_index / column_index width
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_SEL_BIT = 2;  // paddr bit that picks the register

  localparam logic MODE_PICK  = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  localparam logic REG_COLUMN_COUNT = 1'b0;
  localparam logic REG_ROW_COUNT    = 1'b1;

  typedef logic [CFG_W-1:0] dim_t;

endpackage

// File: sv/rfcp_ram.sv
// generic single-write, single-read ram with registered read data
module rfcp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/rfcp_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
module rfcp_divider #(
  parameter int DV_W    = 17,
  parameter int SHORT_W = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       short_op,
  input  logic [rfcp_pkg::RAND_W-1:0] dividend,
  input  logic [DV_W-1:0]            divisor,
  output logic                       busy,
  output logic [rfcp_pkg::RAND_W-1:0] quotient,
  output logic [DV_W-1:0]            remainder
);
  import rfcp_pkg::*;

  localparam int STEP_W = $clog2(RAND_W + 1);

  logic [STEP_W-1:0] steps;
  logic [DV_W-1:0]   dvsr;
  logic [DV_W:0]     trial;
  logic              fits;

  assign busy  = (steps != '0);
  assign trial = {remainder, quotient[RAND_W-1]};
  assign fits  = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= short_op ? STEP_W'(SHORT_W) : STEP_W'(RAND_W);
    end else if (busy) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      dvsr      <= divisor;
      // short operands sit at the top so the msb is shifted in first
      quotient  <= short_op ? (dividend << (RAND_W - SHORT_W)) : dividend;
    end else if (busy) begin
      remainder <= fits ? DV_W'(trial - {1'b0, dvsr}) : trial[DV_W-1:0];
      quotient  <= {quotient[RAND_W-2:0], fits};
    end
  end

endmodule

// File: sv/rfcp_scan.sv
// finds the lowest free bit of one bitmap word inside the probe window
module rfcp_scan #(
  parameter int WORD_W = 32,
  parameter int BIT_W  = 5
) (
  input  logic [WORD_W-1:0] word,
  input  logic              use_start,
  input  logic [BIT_W-1:0]  start_bit,
  input  logic              use_limit,
  input  logic [BIT_W-1:0]  last_bit,
  output logic              found,
  output logic [BIT_W-1:0]  bit_idx
);

  logic [WORD_W-1:0] free;

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      free[j] = !word[j]
             && (!use_start || (BIT_W'(j) >= start_bit))
             && (!use_limit || (BIT_W'(j) <= last_bit));
    end
  end

  always_comb begin
    bit_idx = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (free[j]) begin
        bit_idx = BIT_W'(j);
      end
    end
  end

  assign found = |free;

endmodule

// File: sv/random_free_cell_picker_unit.sv
// Free cell picker: picks a free cell of a rows-by-columns grid by linear probing from a
// random start, marks it and returns its row and column, or flags the grid full. One
// shared restoring divider computes the start index and then the row/column split, and
// each 32-cell bitmap word probed costs a read and a check on the bitmap ram. A clear
// request, and reset, sweep the bitmap one word a cycle, during which no request is
// taken; register writes are taken at any time.
module random_free_cell_picker_unit #(
  parameter int MAX_CELLS = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [rfcp_pkg::RAND_W-1:0]   random_word,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rfcp_pkg::OUT_W-1:0]    row_index,
  output logic [rfcp_pkg::OUT_W-1:0]    column_index,
  output logic                          grid_full,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rfcp_pkg::PADDR_W-1:0]  paddr,
  input  logic [rfcp_pkg::PDATA_W-1:0]  pwdata,
  output logic [rfcp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import rfcp_pkg::*;

  localparam int IDX_W  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CNT_W  = $clog2(MAX_CELLS + 1);
  localparam int PAD    = 2 ** IDX_W;
  localparam int WORD_W = (PAD < 32) ? PAD : 32;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int ROWS   = PAD / WORD_W;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int VIS_W  = $clog2(ROWS + 2);
  localparam int DV_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_START, S_MOD, S_PROBE_RD, S_PROBE_CHK, S_SPLIT, S_EMIT
  } state_t;

  state_t state;

  // registers
  dim_t column_count;
  dim_t row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= CFG_W'(1);
      row_count    <= CFG_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[REG_SEL_BIT])
        REG_COLUMN_COUNT: column_count <= pwdata[CFG_W-1:0];
        REG_ROW_COUNT:    row_count    <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_SEL_BIT])
      REG_COLUMN_COUNT: prdata = PDATA_W'(column_count);
      REG_ROW_COUNT:    prdata = PDATA_W'(row_count);
    endcase
  end

  assign pready = 1'b1;

  // active cell count, refreshed every cycle from the registers
  dim_t              eff_cols;
  dim_t              eff_rows;
  logic [2*CFG_W-1:0] prod;
  logic [CNT_W-1:0]  cells;
  logic [CNT_W-1:0]  last_cell;
  logic [IDX_W:0]    last_shift;
  logic [ROW_W-1:0]  last_row;
  logic [BIT_W-1:0]  last_bit;

  assign eff_cols = (column_count == '0) ? CFG_W'(1) : column_count;
  assign eff_rows = (row_count == '0) ? CFG_W'(1) : row_count;
  assign prod     = eff_rows * eff_cols;

  always_ff @(posedge clk) begin
    cells <= (prod > (2*CFG_W)'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : prod[CNT_W-1:0];
  end

  assign last_cell  = cells - 1'b1;
  assign last_shift = {1'b0, last_cell[IDX_W-1:0]} >> BIT_W;
  assign last_row   = last_shift[ROW_W-1:0];
  assign last_bit   = last_cell[BIT_W-1:0];

  // sequencer registers
  logic [RAND_W-1:0] word_reg;
  logic [ROW_W-1:0]  clr_row;
  logic [ROW_W-1:0]  probe_row;
  logic [BIT_W-1:0]  start_bit;
  logic              first_visit;
  logic [VIS_W-1:0]  visits;
  logic              res_full;

  // divider
  logic              div_start;
  logic              div_short;
  logic [RAND_W-1:0] div_dividend;
  logic [DV_W-1:0]   div_divisor;
  logic              div_busy;
  logic [RAND_W-1:0] div_quo;
  logic [DV_W-1:0]   div_rem;

  // bitmap ram and scan
  logic              ram_we;
  logic [ROW_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic              scan_found;
  logic [BIT_W-1:0]  scan_bit;
  logic [IDX_W-1:0]  found_idx;
  logic [IDX_W-1:0]  start_idx;
  logic [IDX_W:0]    start_shift;
  logic              out_free;

  assign found_idx   = IDX_W'({probe_row, scan_bit});
  assign start_idx   = div_rem[IDX_W-1:0];
  assign start_shift = {1'b0, start_idx} >> BIT_W;
  assign out_free    = !out_valid || !out_stall;
  assign in_stall    = (state != S_IDLE);

  assign div_start    = (state == S_START) || ((state == S_PROBE_CHK) && scan_found);
  assign div_short    = (state == S_PROBE_CHK);
  assign div_dividend = div_short ? RAND_W'(found_idx) : word_reg;
  assign div_divisor  = div_short ? DV_W'(eff_cols) : DV_W'(cells);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = probe_row;
    ram_wdata = ram_rdata | (WORD_W'(1) << scan_bit);
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_row;
      ram_wdata = '0;
    end else if ((state == S_PROBE_CHK) && scan_found) begin
      ram_we = 1'b1;
    end
  end

  rfcp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (probe_row),
    .rdata (ram_rdata)
  );

  rfcp_scan #(
    .WORD_W (WORD_W),
    .BIT_W  (BIT_W)
  ) u_scan (
    .word      (ram_rdata),
    .use_start (first_visit),
    .start_bit (start_bit),
    .use_limit (probe_row == last_row),
    .last_bit  (last_bit),
    .found     (scan_found),
    .bit_idx   (scan_bit)
  );

  rfcp_divider #(
    .DV_W    (DV_W),
    .SHORT_W (IDX_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .short_op  (div_short),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_row   <= '0;
      out_valid <= 1'b0;
    end else begin
      // the emit state loads the next result itself
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == ROW_W'(ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            word_reg <= random_word;
            clr_row  <= '0;
            state    <= (mode == MODE_CLEAR) ? S_CLEAR : S_START;
          end
        end
        S_START: begin
          state <= S_MOD;
        end
        S_MOD: begin
          if (!div_busy) begin
            probe_row   <= start_shift[ROW_W-1:0];
            start_bit   <= start_idx[BIT_W-1:0];
            first_visit <= 1'b1;
            visits      <= '0;
            state       <= S_PROBE_RD;
          end
        end
        S_PROBE_RD: begin
          state <= S_PROBE_CHK;
        end
        S_PROBE_CHK: begin
          if (scan_found) begin
            res_full <= 1'b0;
            state    <= S_SPLIT;
          end else if (visits == VIS_W'(last_row) + VIS_W'(1)) begin
            // start word seen twice: every active cell is used
            res_full <= 1'b1;
            state    <= S_EMIT;
          end else begin
            visits      <= visits + 1'b1;
            first_visit <= 1'b0;
            probe_row   <= (probe_row == last_row) ? '0 : probe_row + 1'b1;
            state       <= S_PROBE_RD;
          end
        end
        S_SPLIT: begin
          if (!div_busy) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            row_index    <= res_full ? '0 : div_quo[OUT_W-1:0];
            column_index <= res_full ? '0 : div_rem[OUT_W-1:0];
            grid_full    <= res_full;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/rfcp_checker.sv
// port-level checks of the free cell picker, bound to the top level
module rfcp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [rfcp_pkg::OUT_W-1:0] row_index,
  input logic [rfcp_pkg::OUT_W-1:0] column_index,
  input logic                       grid_full
);
  import rfcp_pkg::*;

`include "random_free_cell_picker_unit_assert.svh"

  // a full grid reports the origin cell
  `RFCP_ASSERT_NOW(full_at_origin, out_valid && grid_full, (row_index == '0) && (column_index == '0), "full result with nonzero cell")

  // a request keeps the block busy for at least the next cycle
  `RFCP_ASSERT_NEXT(busy_after_request, in_valid && !in_stall, in_stall, "request taken back to back")

  // a new result only follows busy work
  `RFCP_ASSERT_NOW(result_after_work, $rose(out_valid), $past(in_stall), "result without a request in flight")

  // bitmap clear runs right after reset
  `RFCP_ASSERT_NOW(clear_after_reset, $past(rst), in_stall, "request taken during reset clear")

  `RFCP_ASSERT_NEXT(result_holds, out_valid && out_stall, out_valid && $stable(row_index) && $stable(column_index) && $stable(grid_full), "stalled result changed")

endmodule

bind random_free_cell_picker_unit rfcp_checker u_checker (.*);

// File: tb/tb.sv
// self-checking testbench for the random free cell picker
`timescale 1ns / 100ps

module tb;
  import rfcp_pkg::*;

  localparam int MAX_CELLS     = 4096;
  localparam int SWEEP_SETTLE  = 200;  // bitmap clear sweep plus margin
  localparam int PICK_SETTLE   = 400;  // longest pick with a full probe plus margin
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic              mode;
    logic [RAND_W-1:0] word;
    bit                wait_empty;
  } cell_request_t;

  typedef struct {
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] col;
    logic             full;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic               mode        = MODE_PICK;
  logic [RAND_W-1:0]  random_word = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [OUT_W-1:0]   row_index;
  logic [OUT_W-1:0]   column_index;
  logic               grid_full;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  cell_request_t pending_requests[$];
  cell_result_t  expected_cells[$];

  // predictor state
  bit   cell_used [MAX_CELLS];
  dim_t grid_cols = CFG_W'(1);
  dim_t grid_rows = CFG_W'(1);

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int errors             = 0;

  random_free_cell_picker_unit #(.MAX_CELLS(MAX_CELLS)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .random_word(random_word),
    .out_valid(out_valid), .out_stall(out_stall), .row_index(row_index),
    .column_index(column_index), .grid_full(grid_full),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int unsigned active_cells();
    int unsigned cols;
    int unsigned rows;
    int unsigned cells;
    cols  = (grid_cols == 0) ? 1 : grid_cols;
    rows  = (grid_rows == 0) ? 1 : grid_rows;
    cells = cols * rows;
    return (cells > MAX_CELLS) ? MAX_CELLS : cells;
  endfunction

  // linear probe from word mod cells to the first unused cell
  function automatic cell_result_t pick_cell(input logic [RAND_W-1:0] word);
    int unsigned cells;
    int unsigned cols;
    int unsigned idx;
    cell_result_t res;
    cells = active_cells();
    cols  = (grid_cols == 0) ? 1 : grid_cols;
    idx   = word % cells;
    res   = '{row: '0, col: '0, full: 1'b1};
    for (int unsigned k = 0; k < cells; k++) begin
      if (!cell_used[idx]) begin
        cell_used[idx] = 1'b1;
        res.row  = OUT_W'(idx / cols);
        res.col  = OUT_W'(idx % cols);
        res.full = 1'b0;
        break;
      end
      idx = (idx + 1 >= cells) ? 0 : idx + 1;
    end
    return res;
  endfunction

  task automatic log_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : drive_requests
    cell_request_t nxt;
    bit go;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (mode == MODE_CLEAR) begin
          foreach (cell_used[i]) cell_used[i] = 1'b0;
        end else begin
          expected_cells.push_back(pick_cell(random_word));
        end
      end
      if (!in_valid || !in_stall) begin
        go = pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct;
        // hold a marked request until every outstanding result is back
        if (go && pending_requests[0].wait_empty && expected_cells.size() != 0) go = 1'b0;
        if (go) begin
          nxt = pending_requests.pop_front();
          mode        <= nxt.mode;
          random_word <= nxt.word;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    cell_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_cells.size() == 0) begin
          log_error($sformatf("unexpected result row %0d col %0d full %0b",
                              row_index, column_index, grid_full));
        end else begin
          want = expected_cells.pop_front();
          if (row_index !== want.row || column_index !== want.col || grid_full !== want.full)
            log_error($sformatf({"result mismatch: expected row %0d col %0d full %0b, ",
                                 "got row %0d col %0d full %0b"},
                                want.row, want.col, want.full, row_index, column_index,
                                grid_full));
        end
      end
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  task automatic queue_request(input logic req_mode, input logic [RAND_W-1:0] word,
                               input bit wait_empty);
    pending_requests.push_back('{mode: req_mode, word: word, wait_empty: wait_empty});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_cells.size() != 0);
    repeat (SWEEP_SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [PDATA_W-1:0] value);
    logic [PADDR_W-1:0] addr;
    addr = '0;
    addr[REG_SEL_BIT] = sel;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_COLUMN_COUNT) grid_cols = dim_t'(value);
    else grid_rows = dim_t'(value);
  endtask

  task automatic set_grid(input logic [PDATA_W-1:0] cols, input logic [PDATA_W-1:0] rows);
    wait_drained();
    write_reg(REG_COLUMN_COUNT, cols);
    write_reg(REG_ROW_COUNT, rows);
  endtask

  // fill-the-grid runs with random start words, broken by stray clears and skipped clears
  task automatic random_phase(input int unsigned cols, input int unsigned rows,
                              input int unsigned n, input int sender_pct,
                              input int stall_pct);
    int unsigned cells;
    int unsigned pushed;
    int unsigned run;
    set_grid(cols, rows);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = stall_pct;
    cells  = active_cells();
    pushed = 0;
    while (pushed < n) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_request(MODE_CLEAR, RAND_W'($urandom), 1'b0);
        pushed++;
      end else begin
        run = (cells <= 200) ? cells + $urandom_range(0, 3) : $urandom_range(4, 40);
        // keep the phase near its request budget
        if (run > n - pushed) run = n - pushed;
        repeat (run) begin
          if ($urandom_range(0, 3) == 0)
            queue_request(MODE_PICK, RAND_W'($urandom_range(0, 300)),
                          $urandom_range(0, 59) == 0);
          else
            queue_request(MODE_PICK, RAND_W'($urandom), $urandom_range(0, 59) == 0);
          pushed++;
        end
        if ($urandom_range(0, 3) != 0) begin
          queue_request(MODE_CLEAR, RAND_W'($urandom), 1'b0);
          pushed++;
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // single-cell grid from reset values: pick, full, clear ignores its word
    queue_request(MODE_PICK, '0, 1'b0);
    queue_request(MODE_PICK, '1, 1'b0);
    queue_request(MODE_CLEAR, '1, 1'b0);
    queue_request(MODE_PICK, RAND_W'(12345), 1'b0);

    // tallest grid, top row and wraparound probe
    set_grid(1, 4096);
    queue_request(MODE_PICK, '1, 1'b0);
    queue_request(MODE_PICK, RAND_W'(4095), 1'b0);
    queue_request(MODE_CLEAR, '0, 1'b0);

    // widest grid
    set_grid(4096, 1);
    queue_request(MODE_PICK, '1, 1'b0);
    queue_request(MODE_PICK, RAND_W'(8191), 1'b0);

    // oversized registers, cell count capped, upper data bits dropped
    set_grid(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(MODE_PICK, RAND_W'(4095), 1'b0);

    // zero registers act as one, old marks left in place
    set_grid(0, 0);
    queue_request(MODE_PICK, '1, 1'b0);
    queue_request(MODE_CLEAR, '0, 1'b0);
    queue_request(MODE_PICK, '0, 1'b0);

    // fill a 2 by 3 grid until full
    set_grid(3, 2);
    queue_request(MODE_PICK, RAND_W'(5), 1'b0);
    queue_request(MODE_PICK, RAND_W'(5), 1'b0);
    queue_request(MODE_PICK, RAND_W'(5), 1'b0);
    queue_request(MODE_PICK, RAND_W'(2000000000), 1'b0);
    queue_request(MODE_PICK, '1, 1'b0);
    queue_request(MODE_PICK, '0, 1'b0);
    queue_request(MODE_CLEAR, '0, 1'b0);
    queue_request(MODE_PICK, RAND_W'(3), 1'b1);

    random_phase($urandom_range(1, 8), $urandom_range(1, 8), 125, 0, 0);
    random_phase($urandom_range(1, 10), $urandom_range(1, 10), 125, 63, 0);
    random_phase($urandom_range(1, 10), $urandom_range(1, 10), 125, 0, 63);
    random_phase(0, $urandom_range(1, 8), 125, 32, 32);
    random_phase(64, 64, 125, 0, 0);
    random_phase(8191, 3, 125, 63, 0);
    random_phase($urandom_range(1, 8), 0, 125, 0, 63);
    random_phase($urandom_range(1, 12), $urandom_range(1, 12), 125, 32, 32);

    wait_drained();
    repeat (PICK_SETTLE) @(negedge clk);
    if (errors == 0 && expected_cells.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/rfcp_pkg.sv
sv/rfcp_ram.sv
sv/rfcp_divider.sv
sv/rfcp_scan.sv
sv/random_free_cell_picker_unit.sv
sv/rfcp_checker.sv
tb/tb.sv
